// ----- rtl/lrs_pkg.sv -----
// Package for the serpentine line rasterizer.
// Holds matrix geometry, field widths, the queued line job type and the walker states.
// No dependencies.
package lrs_pkg;

    localparam int MATRIX_WIDTH  = 32;
    localparam int MATRIX_HEIGHT = 8;

    localparam int COORD_W   = 6;
    localparam int COLOR_W   = 24;
    localparam int LED_IDX_W = 8;
    localparam int ERR_W     = COORD_W + 3;

    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t               start_x;
        coord_t               start_y;
        coord_t               end_x;
        coord_t               end_y;
        logic [COORD_W-1:0]   dx_mag;
        logic [COORD_W-1:0]   dy_mag;
        logic                 step_x_pos;
        logic                 step_y_pos;
        logic [COLOR_W-1:0]   color;
    } line_job_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

// ----- rtl/lrs_if.sv -----
// Handshake interfaces for line requests and line points.
// Depends on lrs_pkg.
interface lrs_line_if
    import lrs_pkg::*;
();
    logic               valid;
    logic               ready;
    coord_t             start_x;
    coord_t             start_y;
    coord_t             end_x;
    coord_t             end_y;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface lrs_point_if
    import lrs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    coord_t               point_x;
    coord_t               point_y;
    logic                 inside_res;
    logic [LED_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_point;

    modport source (output valid, point_x, point_y, inside_res, led_index, pixel_color,
                    last_point, input ready);
    modport sink (input valid, point_x, point_y, inside_res, led_index, pixel_color,
                  last_point, output ready);
endinterface

// ----- rtl/line_rasterizer_serpentine_top.sv -----
// Top level of the serpentine line rasterizer: front end, job queue and line walker.
// Depends on lrs_pkg, lrs_if, lrs_front, lrs_queue and lrs_walker.
//
//   Port    Dir   Carries
//   line    in    endpoints start_x/start_y, end_x/end_y and line_color
//   point   out   one point per request step with inside flag, LED index and color
//
// A line of N points (N = max(|dx|,|dy|)+1, at most 64) is walked in two steps: the walker
// loads the job, then emits one point per cycle while point is not stalled.
// The front end and a two-entry queue keep accepting requests while a line is walked.
// Reset is asynchronous and empties the queue, the walker and the output register.
// A stall on point holds the output register and freezes the walk; line stalls only
// when the queue is full.
module line_rasterizer_serpentine_top
    import lrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lrs_line_if.sink    line,
    lrs_point_if.source point
);

    line_job_t front_job;
    line_job_t head_job;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;

    lrs_front u_front (
        .line       (line),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    lrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_job  (head_job)
    );

    lrs_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head_job),
        .pop       (pop),
        .point     (point)
    );

endmodule

// ----- rtl/lrs_front.sv -----
// Front end: accepts a line request and works out the deltas and step directions.
// Depends on lrs_pkg and lrs_if.
module lrs_front
    import lrs_pkg::*;
(
    lrs_line_if.sink  line,
    input  logic      queue_full,
    output logic      push,
    output line_job_t job
);

    logic signed [COORD_W:0] diff_x;
    logic signed [COORD_W:0] diff_y;
    logic signed [COORD_W:0] abs_x;
    logic signed [COORD_W:0] abs_y;

    always_comb
    begin
        diff_x = (COORD_W+1)'(line.end_x) - (COORD_W+1)'(line.start_x);
        diff_y = (COORD_W+1)'(line.end_y) - (COORD_W+1)'(line.start_y);
        abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
        abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

        job.start_x    = line.start_x;
        job.start_y    = line.start_y;
        job.end_x      = line.end_x;
        job.end_y      = line.end_y;
        job.dx_mag     = abs_x[COORD_W-1:0];
        job.dy_mag     = abs_y[COORD_W-1:0];
        job.step_x_pos = line.start_x < line.end_x;
        job.step_y_pos = line.start_y < line.end_y;
        job.color      = line.line_color;
    end

    assign line.ready = !queue_full;
    assign push       = line.valid && !queue_full;

endmodule

// ----- rtl/lrs_queue.sv -----
// Short queue of classified line jobs between the front end and the walker.
// Depends on lrs_pkg.
module lrs_queue
    import lrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output line_job_t head_job
);

    line_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/lrs_walker.sv -----
// Back end: walks one Bresenham line a point per unstalled cycle into an output register.
// Computes the inside flag and the serpentine LED index. Depends on lrs_pkg and lrs_if.
module lrs_walker
    import lrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  line_job_t   job,
    output logic        pop,
    lrs_point_if.source point
);

    walk_state_t state_reg;
    walk_state_t state_next;

    line_job_t               job_reg;
    coord_t                  x_reg;
    coord_t                  y_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic                 out_valid_reg;
    coord_t               out_x_reg;
    coord_t               out_y_reg;
    logic                 out_inside_reg;
    logic [LED_IDX_W-1:0] out_index_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;

    logic                  advance;
    logic                  emit;
    logic                  is_last;
    logic                  in_matrix;
    logic [LED_IDX_W-1:0]  x_e;
    logic [LED_IDX_W-1:0]  y_e;
    logic [LED_IDX_W-1:0]  index;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] dx_w;
    logic signed [ERR_W:0] ndy_w;
    logic                  step_x;
    logic                  step_y;
    logic signed [ERR_W-1:0] err_start;
    logic signed [ERR_W-1:0] err_step;

    assign advance = !out_valid_reg || point.ready;
    assign is_last = (x_reg == job_reg.end_x && y_reg == job_reg.end_y)
                     || cnt_reg == CNT_W'(MAX_POINTS - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = WALK_RUN;
                end
            end
            WALK_RUN:
            begin
                if (advance && is_last)
                begin
                    state_next = WALK_IDLE;
                end
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            WALK_IDLE:
            begin
                pop = job_valid;
            end
            WALK_RUN:
            begin
                emit = advance;
            end
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_matrix = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                    && (LED_IDX_W'(x_reg) < LED_IDX_W'(MATRIX_WIDTH))
                    && (LED_IDX_W'(y_reg) < LED_IDX_W'(MATRIX_HEIGHT));
        x_e = LED_IDX_W'($unsigned(x_reg));
        y_e = LED_IDX_W'($unsigned(y_reg));
        if (!in_matrix)
        begin
            index = '0;
        end
        else if (y_reg[0])
        begin
            index = (y_e + 1'b1) * LED_IDX_W'(MATRIX_WIDTH) - 1'b1 - x_e;
        end
        else
        begin
            index = y_e * LED_IDX_W'(MATRIX_WIDTH) + x_e;
        end
    end

    always_comb
    begin
        e2        = $signed({err_reg, 1'b0});
        dx_w      = $signed((ERR_W+1)'(job_reg.dx_mag));
        ndy_w     = -$signed((ERR_W+1)'(job_reg.dy_mag));
        step_x    = e2 >= ndy_w;
        step_y    = e2 <= dx_w;
        err_step  = err_reg;
        if (step_x)
        begin
            err_step = err_step - $signed(ERR_W'(job_reg.dy_mag));
        end
        if (step_y)
        begin
            err_step = err_step + $signed(ERR_W'(job_reg.dx_mag));
        end
        err_start = $signed(ERR_W'(job.dx_mag)) - $signed(ERR_W'(job.dy_mag));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
            x_reg   <= job.start_x;
            y_reg   <= job.start_y;
            err_reg <= err_start;
            cnt_reg <= '0;
        end
        else if (emit && !is_last)
        begin
            if (step_x)
            begin
                x_reg <= job_reg.step_x_pos ? x_reg + 1'b1 : x_reg - 1'b1;
            end
            if (step_y)
            begin
                y_reg <= job_reg.step_y_pos ? y_reg + 1'b1 : y_reg - 1'b1;
            end
            err_reg <= err_step;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (emit)
        begin
            out_x_reg      <= x_reg;
            out_y_reg      <= y_reg;
            out_inside_reg <= in_matrix;
            out_index_reg  <= index;
            out_color_reg  <= job_reg.color;
            out_last_reg   <= is_last;
        end
    end

    assign point.valid       = out_valid_reg;
    assign point.point_x     = out_x_reg;
    assign point.point_y     = out_y_reg;
    assign point.inside_res  = out_inside_reg;
    assign point.led_index   = out_index_reg;
    assign point.pixel_color = out_color_reg;
    assign point.last_point  = out_last_reg;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the serpentine line rasterizer.
// Drives line requests, predicts every Bresenham point and checks each result in order.
// Depends on lrs_pkg, lrs_if and line_rasterizer_serpentine_top.
module tb
    import lrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LINES = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        coord_t             sx;
        coord_t             sy;
        coord_t             ex;
        coord_t             ey;
        logic [COLOR_W-1:0] color;
    } line_req_t;

    typedef struct {
        coord_t               x;
        coord_t               y;
        logic                 in_matrix;
        logic [LED_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   color;
        logic                 last;
    } line_point_t;

    logic clk;
    logic rst_n;

    lrs_line_if  line_bus ();
    lrs_point_if point_bus ();

    line_rasterizer_serpentine_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .line  (line_bus),
        .point (point_bus)
    );

    line_req_t   pending_lines[$];
    line_point_t expected_points[$];

    int  lines_taken    = 0;
    int  total_lines    = 0;
    int  points_checked = 0;
    int  inside_points  = 0;
    int  longest_line   = 0;
    int  errors         = 0;
    int  stall_cycles   = 0;
    int  hold_left      = 0;
    bit  hold_ask       = 0;
    bit  hold_done      = 0;
    bit  steady         = 0;
    bit  line_fire      = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void plot_line(input line_req_t r);
        int x, y, xe, ye, dx, dy, sx, sy, err, e2, n;
        bit last;
        line_point_t p;
        x  = r.sx;
        y  = r.sy;
        xe = r.ex;
        ye = r.ey;
        dx = (xe > x) ? xe - x : x - xe;
        dy = (ye > y) ? y - ye : ye - y;
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx + dy;
        n = 0;
        last = 0;
        while (!last)
        begin
            last = (x == xe && y == ye) || n == MAX_POINTS - 1;
            p.x = coord_t'(x);
            p.y = coord_t'(y);
            p.in_matrix = x >= 0 && x < MATRIX_WIDTH && y >= 0 && y < MATRIX_HEIGHT;
            p.idx = '0;
            if (p.in_matrix)
            begin
                if (y[0])
                    p.idx = LED_IDX_W'((y + 1) * MATRIX_WIDTH - 1 - x);
                else
                    p.idx = LED_IDX_W'(x + y * MATRIX_WIDTH);
            end
            p.color = r.color;
            p.last = last;
            expected_points.push_back(p);
            n++;
            if (!last)
            begin
                e2 = 2 * err;
                if (e2 >= dy)
                begin
                    err += dy;
                    x += sx;
                end
                if (e2 <= dx)
                begin
                    err += dx;
                    y += sy;
                end
            end
        end
        if (n > longest_line)
            longest_line = n;
    endfunction

    function automatic void add_line(input int sx, input int sy, input int ex, input int ey,
                                     input logic [COLOR_W-1:0] color);
        line_req_t r;
        r.sx = coord_t'(sx);
        r.sy = coord_t'(sy);
        r.ex = coord_t'(ex);
        r.ey = coord_t'(ey);
        r.color = color;
        pending_lines.push_back(r);
    endfunction

    // Line request driver.
    always @(negedge clk)
    begin
        line_req_t r;
        if (!rst_n)
            line_bus.valid <= 1'b0;
        else if (!line_bus.valid || line_fire)
        begin
            if (pending_lines.size() != 0 && (steady || $urandom_range(99) >= 21))
            begin
                r = pending_lines.pop_front();
                line_bus.valid      <= 1'b1;
                line_bus.start_x    <= r.sx;
                line_bus.start_y    <= r.sy;
                line_bus.end_x      <= r.ex;
                line_bus.end_y      <= r.ey;
                line_bus.line_color <= r.color;
            end
            else
                line_bus.valid <= 1'b0;
        end
    end

    // Point receiver, with one long hold-off so that the queue fills and the
    // line request side stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            point_bus.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            point_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask && !hold_done)
        begin
            point_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            point_bus.ready <= steady || $urandom_range(99) >= 21;
    end

    // Monitor: check accepted points, then predict for an accepted request.
    always @(posedge clk)
    begin
        line_point_t want;
        line_req_t r;
        line_fire <= rst_n && line_bus.valid && line_bus.ready;
        if (rst_n)
        begin
            if (point_bus.valid && point_bus.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("tb: unexpected point (%0d,%0d) idx=%0d last=%0b",
                                 point_bus.point_x, point_bus.point_y,
                                 point_bus.led_index, point_bus.last_point);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (point_bus.point_x !== want.x || point_bus.point_y !== want.y ||
                        point_bus.inside_res !== want.in_matrix ||
                        point_bus.led_index !== want.idx ||
                        point_bus.pixel_color !== want.color ||
                        point_bus.last_point !== want.last)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                        begin
                            $display("tb: point %0d mismatch", points_checked);
                            $display("tb:   expected (%0d,%0d) in=%0b idx=%0d col=%h last=%0b",
                                     want.x, want.y, want.in_matrix, want.idx,
                                     want.color, want.last);
                            $display("tb:   got      (%0d,%0d) in=%0b idx=%0d col=%h last=%0b",
                                     point_bus.point_x, point_bus.point_y,
                                     point_bus.inside_res, point_bus.led_index,
                                     point_bus.pixel_color, point_bus.last_point);
                        end
                    end
                    if (want.in_matrix)
                        inside_points++;
                    points_checked++;
                end
            end
            if (line_bus.valid && line_bus.ready)
            begin
                r.sx = line_bus.start_x;
                r.sy = line_bus.start_y;
                r.ex = line_bus.end_x;
                r.ey = line_bus.end_y;
                r.color = line_bus.line_color;
                plot_line(r);
                lines_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((line_bus.valid && line_bus.ready) || (point_bus.valid && point_bus.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: no request or point accepted for %0d cycles", STALL_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        line_req_t r;
        int kind, v, directed;
        rst_n = 1'b0;
        line_bus.valid = 1'b0;
        line_bus.start_x = '0;
        line_bus.start_y = '0;
        line_bus.end_x = '0;
        line_bus.end_y = '0;
        line_bus.line_color = '0;
        point_bus.ready = 1'b0;

        add_line(0, 0, 0, 0, 24'h000000);
        add_line(-32, -32, -32, -32, 24'hFFFFFF);
        add_line(31, 7, 31, 7, 24'h123456);
        add_line(-32, -32, 31, 31, 24'hAAAAAA);
        add_line(31, -32, -32, 31, 24'h555555);
        add_line(-32, 0, 31, 0, 24'hFF0000);
        add_line(0, 31, 0, -32, 24'h00FF00);
        add_line(0, 0, 31, 0, 24'h0000FF);
        add_line(31, 1, 0, 1, 24'hFFFFFF);
        add_line(0, 7, 31, 7, 24'h800001);
        add_line(0, 8, 31, 8, 24'h7FFFFE);
        add_line(-1, -1, 32 - 1, 8, 24'h0F0F0F);
        add_line(5, -3, 5, 10, 24'hF0F0F0);
        add_line(3, 0, 10, 7, 24'hC3C3C3);
        add_line(10, 7, 3, 0, 24'h3C3C3C);
        add_line(0, 0, 31, 3, 24'h010203);
        add_line(31, 2, -5, 6, 24'hFEDCBA);
        add_line(20, 15, 25, -20, 24'h999999);
        directed = pending_lines.size();

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            kind = $urandom_range(9);
            r.color = COLOR_W'($urandom);
            if (kind < 3)
            begin
                r.sx = coord_t'($urandom);
                r.sy = coord_t'($urandom);
                r.ex = coord_t'($urandom);
                r.ey = coord_t'($urandom);
            end
            else if (kind < 7)
            begin
                r.sx = coord_t'($urandom_range(35) - 4);
                r.sy = coord_t'($urandom_range(12) - 3);
                r.ex = coord_t'($urandom_range(35) - 4);
                r.ey = coord_t'($urandom_range(12) - 3);
            end
            else
            begin
                r.sx = coord_t'($urandom);
                r.sy = coord_t'($urandom);
                v = int'(r.sx) + int'($urandom_range(6)) - 3;
                r.ex = coord_t'((v > 31) ? 31 : (v < -32) ? -32 : v);
                v = int'(r.sy) + int'($urandom_range(6)) - 3;
                r.ey = coord_t'((v > 31) ? 31 : (v < -32) ? -32 : v);
            end
            pending_lines.push_back(r);
        end
        total_lines = pending_lines.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (lines_taken < directed + 60)
            @(posedge clk);
        hold_ask = 1'b1;
        while (lines_taken < directed + 150)
            @(posedge clk);
        steady = 1'b1;
        while (lines_taken < directed + 250)
            @(posedge clk);
        steady = 1'b0;
        while (lines_taken < total_lines || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_points.size() != 0)
        begin
            errors++;
            $display("tb: %0d expected points never arrived", expected_points.size());
        end
        $display("tb: run covered %0d line requests and %0d points, %0d inside the matrix",
                 lines_taken, points_checked, inside_points);
        $display("tb: longest line %0d points, %0d mismatches", longest_line, errors);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- line_rasterizer_serpentine_top.f -----
rtl/lrs_pkg.sv
rtl/lrs_if.sv
rtl/lrs_front.sv
rtl/lrs_queue.sv
rtl/lrs_walker.sv
rtl/line_rasterizer_serpentine_top.sv
verif/tb.sv
